### rtl/cfrx_pkg.sv
// Shared types and constants for the checksummed frame receiver.
package cfrx_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned PosW  = 9;
  localparam int unsigned TidW  = 16;
  localparam int unsigned StatW = 2;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [ByteW-1:0] SyncFirstReset  = 8'd89;
  localparam logic [ByteW-1:0] SyncSecondReset = 8'd83;
  localparam logic [ByteW-1:0] MaxLenReset     = 8'd250;

  localparam logic [CfgIdxW-1:0] CFG_SYNC_FIRST  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SYNC_SECOND = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_LEN     = 2'd2;

  localparam logic [StatW-1:0] STAT_BUSY    = 2'd0;
  localparam logic [StatW-1:0] STAT_OK      = 2'd1;
  localparam logic [StatW-1:0] STAT_BAD_LEN = 2'd2;
  localparam logic [StatW-1:0] STAT_BAD_SUM = 2'd3;

  localparam logic [PosW-1:0] POS_HUNT    = 9'd0;
  localparam logic [PosW-1:0] POS_HDR     = 9'd1;
  localparam logic [PosW-1:0] POS_TID_LO  = 9'd2;
  localparam logic [PosW-1:0] POS_TID_HI  = 9'd3;
  localparam logic [PosW-1:0] POS_LEN     = 9'd4;
  localparam logic [PosW-1:0] POS_PAYLOAD = 9'd5;

  typedef struct packed {
    logic [ByteW-1:0] sync_first;
    logic [ByteW-1:0] sync_second;
    logic [ByteW-1:0] max_len;
  } cfrx_cfg_t;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic             strobe;
    logic [ByteW-1:0] data;
    logic [ByteW-1:0] index;
    logic [TidW-1:0]  tid;
    logic [ByteW-1:0] length;
  } cfrx_result_t;

endpackage

### rtl/checksummed_frame_receiver_top.sv
// Top level of the checksummed frame receiver.
//
// Input channel rx_*: one received byte per transaction (valid/ready).
// Output channel out_*: exactly one result per accepted byte: status,
// payload strobe with data and index, and on a good frame its id and length.
// Configuration: cfg_we_i writes cfg_wdata_i to the register cfg_idx_i
// (0 first header byte, 1 second header byte, 2 maximum payload length);
// other indexes are ignored. Write only while no transaction is in flight.
// The result is registered and appears in the cycle after the byte is accepted.
// Throughput: one byte per cycle unless stalled; the parser updates its
// position, id, length and Fletcher sums per byte, and the result register
// accepts a new byte in the same cycle its held result is taken.
// Reset: parser returns to hunting with cleared sums, registers take their
// defaults (0x59, 0x53, 250), and no result is held.
// Stall: while out_ready_i is low with a result held, rx_ready_o drops and
// the parser state holds.
module checksummed_frame_receiver_top
  import cfrx_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [ByteW-1:0]   cfg_wdata_i,
  input  logic               rx_valid_i,
  output logic               rx_ready_o,
  input  logic [ByteW-1:0]   rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [StatW-1:0]   status_o,
  output logic               payload_strobe_o,
  output logic [ByteW-1:0]   payload_data_o,
  output logic [ByteW-1:0]   payload_index_o,
  output logic [TidW-1:0]    frame_tid_o,
  output logic [ByteW-1:0]   frame_length_o
);

  cfrx_cfg_t    cfg_q;
  cfrx_result_t result;
  cfrx_result_t result_out;
  logic         accept;

  assign accept = rx_valid_i && rx_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_first  <= SyncFirstReset;
      cfg_q.sync_second <= SyncSecondReset;
      cfg_q.max_len     <= MaxLenReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SYNC_FIRST:  cfg_q.sync_first  <= cfg_wdata_i;
        CFG_SYNC_SECOND: cfg_q.sync_second <= cfg_wdata_i;
        CFG_MAX_LEN:     cfg_q.max_len     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  cfrx_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (rx_byte_i),
    .cfg_i     (cfg_q),
    .result_o  (result)
  );

  cfrx_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (rx_valid_i),
    .in_ready_o  (rx_ready_o),
    .in_data_i   (result),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (result_out)
  );

  assign status_o         = result_out.status;
  assign payload_strobe_o = result_out.strobe;
  assign payload_data_o   = result_out.data;
  assign payload_index_o  = result_out.index;
  assign frame_tid_o      = result_out.tid;
  assign frame_length_o   = result_out.length;

endmodule

### rtl/cfrx_parser.sv
// Frame parser state and per-byte result logic.
module cfrx_parser
  import cfrx_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [ByteW-1:0] rx_byte_i,
  input  cfrx_cfg_t        cfg_i,
  output cfrx_result_t     result_o
);

  logic [PosW-1:0]  pos_q, pos_d;
  logic [TidW-1:0]  tid_q, tid_d;
  logic [ByteW-1:0] len_q, len_d;
  logic [ByteW-1:0] sum_a_q, sum_a_d;
  logic [ByteW-1:0] sum_b_q, sum_b_d;
  logic [ByteW-1:0] chk_a_q, chk_a_d;
  logic [PosW-1:0]  chk_a_pos;
  logic [PosW-1:0]  chk_b_pos;
  logic [PosW-1:0]  pay_off;
  logic [ByteW-1:0] sum_a_add;
  logic [ByteW-1:0] sum_b_add;
  logic             do_sum;

  assign chk_a_pos = POS_PAYLOAD + {1'b0, len_q};
  assign chk_b_pos = chk_a_pos + 9'd1;
  assign pay_off   = pos_q - POS_PAYLOAD;
  assign sum_a_add = sum_a_q + rx_byte_i;
  assign sum_b_add = sum_b_q + sum_a_add;

  always_comb begin
    pos_d   = pos_q;
    tid_d   = tid_q;
    len_d   = len_q;
    chk_a_d = chk_a_q;
    do_sum  = 1'b0;
    sum_a_d = sum_a_q;
    sum_b_d = sum_b_q;
    result_o = '0;
    if (pos_q == POS_HUNT) begin
      if (rx_byte_i == cfg_i.sync_first) pos_d = POS_HDR;
    end else if (pos_q == POS_HDR) begin
      if (rx_byte_i == cfg_i.sync_second) begin
        pos_d   = POS_TID_LO;
        sum_a_d = '0;
        sum_b_d = '0;
      end else if (rx_byte_i == cfg_i.sync_first) begin
        pos_d = POS_HDR;
      end else begin
        pos_d = POS_HUNT;
      end
    end else if (pos_q == POS_TID_LO) begin
      tid_d  = {tid_q[TidW-1:ByteW], rx_byte_i};
      do_sum = 1'b1;
      pos_d  = POS_TID_HI;
    end else if (pos_q == POS_TID_HI) begin
      tid_d  = {rx_byte_i, tid_q[ByteW-1:0]};
      do_sum = 1'b1;
      pos_d  = POS_LEN;
    end else if (pos_q == POS_LEN) begin
      len_d = rx_byte_i;
      if (rx_byte_i == '0 || rx_byte_i > cfg_i.max_len) begin
        result_o.status = STAT_BAD_LEN;
        pos_d = POS_HUNT;
      end else begin
        do_sum = 1'b1;
        pos_d  = POS_PAYLOAD;
      end
    end else if (pos_q < chk_a_pos) begin
      do_sum          = 1'b1;
      result_o.strobe = 1'b1;
      result_o.data   = rx_byte_i;
      result_o.index  = pay_off[ByteW-1:0];
      pos_d           = pos_q + 9'd1;
    end else if (pos_q == chk_a_pos) begin
      chk_a_d = rx_byte_i;
      pos_d   = pos_q + 9'd1;
    end else if (pos_q == chk_b_pos) begin
      if (chk_a_q == sum_a_q && rx_byte_i == sum_b_q) begin
        result_o.status = STAT_OK;
        result_o.tid    = tid_q;
        result_o.length = len_q;
      end else begin
        result_o.status = STAT_BAD_SUM;
      end
      pos_d = POS_HUNT;
    end else begin
      pos_d = POS_HUNT;
    end
    if (do_sum) begin
      sum_a_d = sum_a_add;
      sum_b_d = sum_b_add;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= POS_HUNT;
      tid_q   <= '0;
      len_q   <= '0;
      sum_a_q <= '0;
      sum_b_q <= '0;
      chk_a_q <= '0;
    end else if (accept_i) begin
      pos_q   <= pos_d;
      tid_q   <= tid_d;
      len_q   <= len_d;
      sum_a_q <= sum_a_d;
      sum_b_q <= sum_b_d;
      chk_a_q <= chk_a_d;
    end
  end

endmodule

### rtl/cfrx_out_reg.sv
// Result register with valid/ready handshake toward the consumer.
module cfrx_out_reg
  import cfrx_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  cfrx_result_t in_data_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output cfrx_result_t out_data_o
);

  logic         valid_q;
  cfrx_result_t data_q;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= in_data_i;
    end
  end

endmodule

### sim/cfrx_checker.sv
// Predicts the frame receiver's result for every received byte and compares what it delivers.
`timescale 1ns / 1ps

module cfrx_checker
  import cfrx_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [ByteW-1:0]   cfg_wdata_i,
  input  logic               rx_valid_i,
  input  logic               rx_ready_i,
  input  logic [ByteW-1:0]   rx_byte_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [StatW-1:0]   status_i,
  input  logic               payload_strobe_i,
  input  logic [ByteW-1:0]   payload_data_i,
  input  logic [ByteW-1:0]   payload_index_i,
  input  logic [TidW-1:0]    frame_tid_i,
  input  logic [ByteW-1:0]   frame_length_i,
  output int unsigned        fail_count_o,
  output int unsigned        in_flight_o
);

  logic [ByteW-1:0] sync_first;
  logic [ByteW-1:0] sync_second;
  logic [ByteW-1:0] max_len;

  logic [PosW-1:0]  frame_pos;
  logic [TidW-1:0]  frame_tid;
  logic [ByteW-1:0] frame_len;
  logic [ByteW-1:0] sum_a;
  logic [ByteW-1:0] sum_b;
  logic [ByteW-1:0] rx_check_a;

  cfrx_result_t parsed_results_q[$];
  cfrx_result_t want;
  cfrx_result_t got;

  initial fail_count_o = 0;

  function automatic void fold_into_sums(input logic [ByteW-1:0] b);
    sum_a = sum_a + b;
    sum_b = sum_b + sum_a;
  endfunction

  function automatic cfrx_result_t parse_rx_byte(input logic [ByteW-1:0] b);
    cfrx_result_t r;
    int unsigned  at;
    r  = '0;
    at = frame_pos;
    if (at == POS_HUNT) begin
      if (b == sync_first) frame_pos = POS_HDR;
    end else if (at == POS_HDR) begin
      if (b == sync_second) begin
        frame_pos = POS_TID_LO;
        sum_a     = '0;
        sum_b     = '0;
      end else if (b == sync_first) begin
        frame_pos = POS_HDR;
      end else begin
        frame_pos = POS_HUNT;
      end
    end else if (at == POS_TID_LO) begin
      frame_tid[7:0] = b;
      fold_into_sums(b);
      frame_pos = POS_TID_HI;
    end else if (at == POS_TID_HI) begin
      frame_tid[15:8] = b;
      fold_into_sums(b);
      frame_pos = POS_LEN;
    end else if (at == POS_LEN) begin
      frame_len = b;
      if (b == 0 || b > max_len) begin
        r.status  = STAT_BAD_LEN;
        frame_pos = POS_HUNT;
      end else begin
        fold_into_sums(b);
        frame_pos = POS_PAYLOAD;
      end
    end else if (at < POS_PAYLOAD + frame_len) begin
      fold_into_sums(b);
      r.strobe  = 1'b1;
      r.data    = b;
      r.index   = ByteW'(at - POS_PAYLOAD);
      frame_pos = PosW'(at + 1);
    end else if (at == POS_PAYLOAD + frame_len) begin
      rx_check_a = b;
      frame_pos  = PosW'(at + 1);
    end else if (at == POS_PAYLOAD + 1 + frame_len) begin
      if (rx_check_a == sum_a && b == sum_b) begin
        r.status = STAT_OK;
        r.tid    = frame_tid;
        r.length = frame_len;
      end else begin
        r.status = STAT_BAD_SUM;
      end
      frame_pos = POS_HUNT;
    end else begin
      frame_pos = POS_HUNT;
    end
    return r;
  endfunction

  task automatic note_mismatch(input string what);
    fail_count_o++;
    if (fail_count_o <= 10)
      $display({"%0t %s: want st=%0d stb=%0d data=%02h idx=%0d tid=%04h len=%0d,",
                " got st=%0d stb=%0d data=%02h idx=%0d tid=%04h len=%0d"},
               $realtime, what, want.status, want.strobe, want.data, want.index,
               want.tid, want.length, got.status, got.strobe, got.data, got.index,
               got.tid, got.length);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first  = SyncFirstReset;
      sync_second = SyncSecondReset;
      max_len     = MaxLenReset;
      frame_pos   = POS_HUNT;
      frame_tid   = '0;
      frame_len   = '0;
      sum_a       = '0;
      sum_b       = '0;
      rx_check_a  = '0;
      parsed_results_q.delete();
      in_flight_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = '{status: status_i, strobe: payload_strobe_i, data: payload_data_i,
                index: payload_index_i, tid: frame_tid_i, length: frame_length_i};
        if (parsed_results_q.size() == 0) begin
          want = '0;
          note_mismatch("unexpected transaction");
        end else begin
          want = parsed_results_q.pop_front();
          if (got.status !== want.status || got.strobe !== want.strobe ||
              got.data !== want.data || got.index !== want.index ||
              got.tid !== want.tid || got.length !== want.length)
            note_mismatch("result mismatch");
        end
      end
      if (rx_valid_i && rx_ready_i) parsed_results_q.push_back(parse_rx_byte(rx_byte_i));
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SYNC_FIRST:  sync_first  = cfg_wdata_i;
          CFG_SYNC_SECOND: sync_second = cfg_wdata_i;
          CFG_MAX_LEN:     max_len     = cfg_wdata_i;
          default: ;
        endcase
      end
      in_flight_o = parsed_results_q.size();
    end
  end

endmodule

### sim/testbench.sv
// Drives byte streams and register settings into the frame receiver and reports the verdict.
`timescale 1ns / 1ps

module testbench;
  import cfrx_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;
  localparam int unsigned NoCut = 1000;

  typedef enum int unsigned {CK_GOOD, CK_BAD_A, CK_BAD_B} ck_fault_e;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i   = '0;
  logic [ByteW-1:0]   cfg_wdata_i = '0;
  logic               rx_valid_i  = 1'b0;
  logic               rx_ready_o;
  logic [ByteW-1:0]   rx_byte_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [StatW-1:0]   status_o;
  logic               payload_strobe_o;
  logic [ByteW-1:0]   payload_data_o;
  logic [ByteW-1:0]   payload_index_o;
  logic [TidW-1:0]    frame_tid_o;
  logic [ByteW-1:0]   frame_length_o;
  int unsigned        fail_count;
  int unsigned        in_flight;

  bit               stall_en   = 1'b1;
  int unsigned      bytes_sent = 0;
  logic [ByteW-1:0] hdr_first  = SyncFirstReset;
  logic [ByteW-1:0] hdr_second = SyncSecondReset;
  logic [ByteW-1:0] len_limit  = MaxLenReset;

  always #2 clk_i = ~clk_i;

  checksummed_frame_receiver_top DUT (.*);

  cfrx_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .rx_valid_i, .rx_ready_i(rx_ready_o), .rx_byte_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .status_i(status_o), .payload_strobe_i(payload_strobe_o),
    .payload_data_i(payload_data_o), .payload_index_i(payload_index_o),
    .frame_tid_i(frame_tid_o), .frame_length_i(frame_length_o),
    .fail_count_o(fail_count), .in_flight_o(in_flight)
  );

  always @(negedge clk_i) out_ready_i <= !stall_en || ($urandom_range(99) >= 12);

  task automatic send_byte(input logic [ByteW-1:0] b);
    while (stall_en && $urandom_range(99) < 12) begin
      rx_valid_i = 1'b0;
      @(negedge clk_i);
    end
    rx_valid_i = 1'b1;
    rx_byte_i  = b;
    do @(posedge clk_i); while (!rx_ready_o);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    rx_valid_i = 1'b0;
    while (in_flight != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] val);
    drain();
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    case (idx)
      CFG_SYNC_FIRST:  hdr_first  = val;
      CFG_SYNC_SECOND: hdr_second = val;
      CFG_MAX_LEN:     len_limit  = val;
      default: ;
    endcase
  endtask

  // cut: number of bytes after the header to send before abandoning the frame
  task automatic send_frame(input logic [TidW-1:0] tid, input logic [ByteW-1:0] len,
                            input ck_fault_e fault, input int unsigned cut);
    logic [ByteW-1:0] body[$];
    logic [ByteW-1:0] fa;
    logic [ByteW-1:0] fb;
    logic [ByteW-1:0] flip;
    fa   = '0;
    fb   = '0;
    flip = ByteW'($urandom_range(255, 1));
    body = {tid[7:0], tid[15:8], len};
    if (len != 0 && len <= len_limit)
      repeat (len) body.push_back(ByteW'($urandom_range(255)));
    send_byte(hdr_first);
    send_byte(hdr_second);
    foreach (body[i]) begin
      if (i >= cut) return;
      fa = fa + body[i];
      fb = fb + fa;
      send_byte(body[i]);
    end
    if (len == 0 || len > len_limit || cut <= body.size()) return;
    send_byte(fault == CK_BAD_A ? fa ^ flip : fa);
    send_byte(fault == CK_BAD_B ? fb ^ flip : fb);
  endtask

  function automatic logic [ByteW-1:0] pick_len();
    int unsigned roll;
    roll = $urandom_range(9);
    if (len_limit == 0 || roll == 0) return ByteW'($urandom_range(255));
    if (roll == 1) return len_limit;
    if (roll == 2) return ByteW'($urandom_range(len_limit, 1));
    return ByteW'($urandom_range(len_limit < 12 ? len_limit : 12, 1));
  endfunction

  task automatic run_random_traffic(input int unsigned quota);
    int unsigned first_count;
    int unsigned pick;
    logic [ByteW-1:0] len;
    first_count = bytes_sent;
    while (bytes_sent - first_count < quota) begin
      pick = $urandom_range(99);
      len  = pick_len();
      if (pick < 70) begin
        send_frame(TidW'($urandom), len, CK_GOOD, NoCut);
      end else if (pick < 80) begin
        send_frame(TidW'($urandom), len, $urandom_range(1) ? CK_BAD_A : CK_BAD_B, NoCut);
      end else if (pick < 86) begin
        send_frame(TidW'($urandom), ByteW'($urandom_range(255)), CK_GOOD, NoCut);
      end else if (pick < 92) begin
        send_frame(TidW'($urandom), len, CK_GOOD, $urandom_range(len + 4));
      end else begin
        repeat ($urandom_range(6, 1))
          send_byte($urandom_range(7) == 0 ? hdr_first : ByteW'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(hdr_first);
    send_byte(8'h00);
    send_byte(hdr_first);
    send_frame(16'hFFFF, 8'd1, CK_GOOD, NoCut);
    send_frame(16'h0000, 8'd0, CK_GOOD, NoCut);
    send_frame(16'h1234, 8'd251, CK_GOOD, NoCut);
    send_frame(16'h8001, 8'd2, CK_BAD_A, NoCut);
    send_frame(16'h00FF, 8'd1, CK_BAD_B, NoCut);

    run_random_traffic(250);

    write_reg(CFG_SYNC_FIRST, 8'h00);
    write_reg(CFG_SYNC_SECOND, 8'hFF);
    write_reg(CFG_MAX_LEN, 8'hFF);
    write_reg(CfgSpare, 8'hA5);
    run_random_traffic(300);

    write_reg(CFG_SYNC_FIRST, 8'hFF);
    write_reg(CFG_SYNC_SECOND, 8'h00);
    write_reg(CFG_MAX_LEN, 8'd1);
    stall_en = 1'b0;
    run_random_traffic(250);
    stall_en = 1'b1;

    write_reg(CFG_SYNC_FIRST, 8'h7E);
    write_reg(CFG_SYNC_SECOND, 8'h7E);
    write_reg(CFG_MAX_LEN, ByteW'($urandom_range(40, 2)));
    run_random_traffic(200);

    write_reg(CFG_MAX_LEN, 8'd0);
    run_random_traffic(80);

    write_reg(CFG_SYNC_FIRST, ByteW'($urandom_range(255)));
    write_reg(CFG_SYNC_SECOND, ByteW'($urandom_range(255)));
    write_reg(CFG_MAX_LEN, ByteW'($urandom_range(255, 1)));
    run_random_traffic(200);

    drain();
    repeat (10) @(negedge clk_i);
    if (fail_count == 0 && in_flight == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
